### src/lkv_pkg.sv
`default_nettype none
package lkv_pkg;

  // fixed field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // one request item as held in the input register
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_req_t;

  // lookup answer produced by the entry table
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [VAL_W-1:0] value;
  } lkv_resp_t;

endpackage
`default_nettype wire

### src/lru_key_value_cache.sv
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// Input channel: an item (in_opcode, in_lookup_key, in_store_value) is taken
// at a rising edge where start is high and busy is low. busy stays low, so
// one item can be issued every cycle.
// A get answers with one result: out_valid is high for exactly one cycle
// with out_hit and out_read_value (zero on a miss). A put gives no result.
// An item taken at a rising edge is held in the input register and is looked
// up from it in the next cycle; its result is registered in the result
// register that drives the out_ ports. Throughput is one item per cycle;
// the table update of one item lands before the next item is looked up,
// so back-to-back items always see fresh state.
// The receiver cannot stall: each result is accepted at the edge that ends
// its strobe cycle.
// Configuration: cfg_capacity_in_use is written when cfg_valid is high;
// cfg_ready is always high. Write it only while no item is in flight.
// Reset (rst_n low, synchronous) empties the store, sets the capacity to 16
// and drops any item in flight.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_opcode,
  input  wire logic [KEY_W-1:0] in_lookup_key,
  input  wire logic [VAL_W-1:0] in_store_value,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [VAL_W-1:0]      out_read_value,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_capacity_in_use
);

  lkv_req_t         req_r, req_nxt;
  lkv_resp_t        resp;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_value_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // input register
  always_comb begin
    req_nxt.valid = start && !busy;
    req_nxt.op    = in_opcode;
    req_nxt.key   = in_lookup_key;
    req_nxt.value = in_store_value;
  end

  // capacity register
  assign cap_nxt = (cfg_valid && cfg_ready) ? cfg_capacity_in_use : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      req_r       <= req_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= resp.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_hit_r   <= resp.hit;
    out_value_r <= resp.value;
  end

  // lookup and replacement table
  lkv_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .capacity(cap_r),
    .resp    (resp)
  );

  // result register outputs
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

endmodule
`default_nettype wire

### src/lkv_table.sv
`default_nettype none
module lkv_table
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lkv_req_t         req,
  input  wire logic [CAP_W-1:0] capacity,
  output lkv_resp_t             resp
);

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [RW-1:0]          rank_r   [MAX_ENTRIES];
  logic [RW-1:0]          rank_nxt [MAX_ENTRIES];
  logic [KEY_W-1:0]       key_r    [MAX_ENTRIES];
  logic [VAL_W-1:0]       value_r  [MAX_ENTRIES];
  logic [CW-1:0]          occ_r, occ_nxt;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [MAX_ENTRIES-1:0] free_vec;
  logic [MAX_ENTRIES-1:0] lowest_free;
  logic [MAX_ENTRIES-1:0] slot_sel;
  logic                   any_match;
  logic [RW-1:0]          hit_rank;
  logic [VAL_W-1:0]       hit_value;
  logic [CW-1:0]          occ_m1;
  logic [LW-1:0]          cap_ext;
  logic [LW-1:0]          limit;
  logic                   evict;
  logic                   is_put;
  logic                   ins_new;

  // parallel key compare and selection of the matching entry
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    occ_m1    = occ_r - CW'(1);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i]  = valid_r[i] && (key_r[i] == req.key);
      victim_vec[i] = valid_r[i] && (CW'(rank_r[i]) == occ_m1);
      hit_rank      = hit_rank  | (match_vec[i] ? rank_r[i]  : '0);
      hit_value     = hit_value | (match_vec[i] ? value_r[i] : '0);
    end
    any_match = |match_vec;
  end

  // effective capacity and slot choice for a new key
  always_comb begin
    cap_ext = LW'(capacity);
    if (capacity == '0) begin
      limit = LW'(1);
    end else if (cap_ext > LW'(MAX_ENTRIES)) begin
      limit = LW'(MAX_ENTRIES);
    end else begin
      limit = cap_ext;
    end
    evict       = (LW'(occ_r) >= limit) && (occ_r != '0);
    free_vec    = ~valid_r;
    lowest_free = free_vec & (~free_vec + MAX_ENTRIES'(1));
    slot_sel    = evict ? victim_vec : lowest_free;
    is_put      = (req.op == OP_PUT);
    ins_new     = req.valid && is_put && !any_match;
  end

  // next entry state: touch on hit, age and fill on insert
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (req.valid && any_match) begin
        if (match_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end else if (ins_new) begin
        if (slot_sel[i]) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
    if (ins_new && !evict) begin
      occ_nxt = occ_r + CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (req.valid && is_put && match_vec[i]) begin
        value_r[i] <= req.value;
      end else if (ins_new && slot_sel[i]) begin
        key_r[i]   <= req.key;
        value_r[i] <= req.value;
      end
    end
  end

  // answer for a get
  always_comb begin
    resp.valid = req.valid && (req.op == OP_GET);
    resp.hit   = any_match;
    resp.value = hit_value;
  end

  // keys held are unique
  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one entry matches the key");

  // occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy count out of step with valid bits");

  // an insert without eviction grows the store by one
  a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_new && !evict) |=> (occ_r == $past(occ_r) + CW'(1)))
    else $error("occupancy did not grow on insert");

  // an eviction has exactly one least recent entry to pick
  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_new && evict) |-> $onehot(victim_vec))
    else $error("no unique least recent entry on eviction");

endmodule
`default_nettype wire
